[hw/rtl/lfe_pkg.sv]
`timescale 1ns / 1ps

package lfe_pkg;

   localparam int POS_W    = 6;
   localparam int ENERGY_W = 21;
   localparam int CORR_W   = 10;
   localparam int WALK_W   = 9;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_BUILD  = 2'd1,
      FUNC_EVAL   = 2'd2,
      FUNC_COMMIT = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      WALK_DIAG   = 2'd0,
      WALK_MIRROR = 2'd1,
      WALK_COLUMN = 2'd2,
      WALK_DONE   = 2'd3
   } walk_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_BLD_RD,
      ST_BLD_WR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_FLIP_RD,
      ST_FLIP_WR,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic zero;
      logic neg;
   } prod_type;

   typedef struct packed {
      logic capture;
      logic cnt_clear;
      logic sign_wr;
      logic bld_issue;
      logic bld_write;
      logic copy_issue;
      logic copy_write;
      logic walk_issue;
      logic walk_write;
      logic walk_step;
      logic flip_issue;
      logic flip_write;
      logic sum_issue;
      logic sum_acc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     pos_valid;
      logic     bld_last;
      logic     copy_last;
      logic     walk_done;
      logic     touch_ok;
      logic     sum_last;
   } sts_type;

endpackage

[hw/rtl/lfe_datapath.sv]
`timescale 1ns / 1ps

module lfe_datapath #(
   parameter int SEQ_LEN = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lfe_pkg::cmd_type                 cmd,
   output lfe_pkg::sts_type                 sts,
   input  logic [1:0]                       req_func,
   input  logic [lfe_pkg::POS_W-1:0]        req_position,
   input  logic                             req_sign_bit,
   output logic [lfe_pkg::ENERGY_W-1:0]     rsp_energy
);

   localparam int HALF   = SEQ_LEN / 2;
   localparam int FREE   = (SEQ_LEN + 1) / 2;
   localparam int RW     = $clog2(HALF);
   localparam int SW     = $clog2(FREE);
   localparam int KW     = RW + 1;
   localparam int TDEPTH = 1 << (2 * RW);
   localparam int CDEPTH = 1 << (RW + 1);
   localparam logic HALF_ODD = 1'(HALF % 2);
   localparam int CW = lfe_pkg::CORR_W;
   localparam int WW = lfe_pkg::WALK_W;

   lfe_pkg::func_type  func_ff;
   logic [lfe_pkg::POS_W-1:0] pos_ff;
   logic               sgn_ff;
   logic [RW-1:0]      i_ff, i_in, j_ff, j_in, row_ff, row_in;
   logic [KW-1:0]      k_ff, k_in;
   lfe_pkg::walk_type  phase_ff, phase_in;
   logic signed [CW-1:0] acc_ff, acc_in;
   logic [lfe_pkg::ENERGY_W-1:0] energy_ff, energy_in, rsp_energy_ff;

   logic               sign_mem [0:FREE-1];
   lfe_pkg::prod_type  tbl_mem [0:TDEPTH-1];
   logic signed [CW-1:0] corr_mem [0:CDEPTH-1];

   logic               sign_a_ff, sign_b_ff, bneg_ff, bzero_ff;
   lfe_pkg::prod_type  tbl_rd_ff;
   logic signed [CW-1:0] corr_rd_ff;

   logic               pos_valid;
   logic [SW-1:0]      pos_addr;
   logic               bank;

   // Build addressing.
   logic [WW-1:0]      idx2, mirror_idx;
   logic [SW-1:0]      b_addr;
   logic               b_neg, b_zero;
   logic               bld_row_end;
   logic               prod_neg;
   logic signed [CW-1:0] contrib;

   // Walk addressing.
   logic signed [WW-1:0] bit_s, k_s, half_s, nm_s;
   logic signed [WW-1:0] walk_r, walk_c, walk_lim;
   logic               in_range, coord_ok, advance;
   logic [2*RW-1:0]    walk_taddr;
   logic signed [CW-1:0] walk_v;
   logic signed [2*CW-1:0] sq;

   assign pos_valid = {1'b0, pos_ff} < (lfe_pkg::POS_W + 1)'(FREE);
   assign pos_addr  = SW'(pos_ff);
   assign bank      = (func_ff == lfe_pkg::FUNC_EVAL);

   always_comb begin
      idx2       = WW'(j_ff) + (WW'(i_ff) << 1) + WW'(2);
      mirror_idx = WW'(SEQ_LEN - 1) - idx2;
      b_addr     = SW'(idx2);
      b_neg      = 1'b0;
      b_zero     = 1'b0;
      if (idx2 >= WW'(SEQ_LEN)) begin
         b_zero = 1'b1;
      end else if (idx2 >= WW'(FREE)) begin
         b_addr = SW'(mirror_idx);
         b_neg  = mirror_idx[0] ^ HALF_ODD;
      end
   end

   assign bld_row_end = ({1'b0, j_ff} + {1'b0, i_ff}) == (RW + 1)'(HALF - 1);
   assign prod_neg    = sign_a_ff ^ sign_b_ff ^ bneg_ff;

   always_comb begin
      if (bzero_ff) begin
         contrib = '0;
      end else if (bld_row_end) begin
         contrib = prod_neg ? -CW'(1) : CW'(1);
      end else begin
         contrib = prod_neg ? -CW'(2) : CW'(2);
      end
   end

   assign bit_s  = $signed(WW'(pos_ff));
   assign k_s    = $signed(WW'(k_ff));
   assign half_s = $signed(WW'(HALF));
   assign nm_s   = $signed(WW'(SEQ_LEN - 1)) - bit_s;

   always_comb begin
      walk_r   = '0;
      walk_c   = '0;
      walk_lim = '0;
      case (phase_ff)
         lfe_pkg::WALK_DIAG: begin
            walk_r   = k_s;
            walk_c   = bit_s - $signed(WW'(2)) - (k_s <<< 1);
            walk_lim = bit_s >>> 1;
         end
         lfe_pkg::WALK_MIRROR: begin
            walk_r   = half_s - bit_s + k_s;
            walk_c   = bit_s - $signed(WW'(2)) - (k_s <<< 1);
            walk_lim = (nm_s != bit_s) ? (bit_s >>> 1) : '0;
         end
         lfe_pkg::WALK_COLUMN: begin
            walk_r   = k_s;
            walk_c   = bit_s;
            walk_lim = half_s - bit_s - $signed(WW'(1));
         end
         default: begin
            walk_r   = '0;
         end
      endcase
   end

   assign in_range   = k_s < walk_lim;
   assign coord_ok   = (walk_r >= 0) && (walk_r < half_s) && (walk_c >= 0) && (walk_c < half_s);
   assign advance    = cmd.walk_step || cmd.walk_write;
   assign walk_taddr = {walk_r[RW-1:0], walk_c[RW-1:0]};

   always_comb begin
      if (tbl_rd_ff.zero) begin
         walk_v = '0;
      end else begin
         walk_v = tbl_rd_ff.neg ? -CW'(4) : CW'(4);
      end
   end

   assign sq = corr_rd_ff * corr_rd_ff;

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      row_in    = row_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      energy_in = energy_ff;
      if (cmd.cnt_clear) begin
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
         row_in    = '0;
         phase_in  = lfe_pkg::WALK_DIAG;
         acc_in    = '0;
         energy_in = '0;
      end else begin
         if (cmd.bld_write) begin
            if (bld_row_end) begin
               j_in   = '0;
               i_in   = i_ff + RW'(1);
               acc_in = '0;
            end else begin
               j_in   = j_ff + RW'(1);
               acc_in = acc_ff + contrib;
            end
         end
         if (advance) begin
            if (!in_range || (k_s + $signed(WW'(1)) == walk_lim)) begin
               phase_in = lfe_pkg::walk_type'(2'(phase_ff + 2'd1));
               k_in     = '0;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         if (cmd.copy_write || cmd.sum_acc) begin
            row_in = row_ff + RW'(1);
         end
         if (cmd.sum_acc) begin
            energy_in = energy_ff + lfe_pkg::ENERGY_W'($unsigned(sq));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         row_ff    <= '0;
         phase_ff  <= lfe_pkg::WALK_DIAG;
         acc_ff    <= '0;
         energy_ff <= '0;
      end else begin
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         row_ff    <= row_in;
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         energy_ff <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= lfe_pkg::func_type'(req_func);
         pos_ff  <= req_position;
         sgn_ff  <= req_sign_bit;
      end
      if (cmd.out_load) begin
         if (func_ff == lfe_pkg::FUNC_BUILD || func_ff == lfe_pkg::FUNC_EVAL) begin
            rsp_energy_ff <= energy_ff;
         end else begin
            rsp_energy_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bld_issue) begin
         sign_a_ff <= sign_mem[SW'(j_ff)];
         sign_b_ff <= sign_mem[b_addr];
         bneg_ff   <= b_neg;
         bzero_ff  <= b_zero;
      end else if (cmd.flip_issue) begin
         sign_a_ff <= sign_mem[pos_addr];
      end
      if (cmd.sign_wr && pos_valid) begin
         sign_mem[pos_addr] <= sgn_ff;
      end else if (cmd.flip_write) begin
         sign_mem[pos_addr] <= ~sign_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_issue) begin
         tbl_rd_ff <= tbl_mem[walk_taddr];
      end
      if (cmd.bld_write) begin
         tbl_mem[{i_ff, j_ff}] <= '{zero: bzero_ff, neg: prod_neg};
      end else if (cmd.walk_write && !bank) begin
         tbl_mem[walk_taddr] <= '{zero: tbl_rd_ff.zero, neg: ~tbl_rd_ff.neg};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_issue) begin
         corr_rd_ff <= corr_mem[{bank, walk_r[RW-1:0]}];
      end else if (cmd.copy_issue) begin
         corr_rd_ff <= corr_mem[{1'b0, row_ff}];
      end else if (cmd.sum_issue) begin
         corr_rd_ff <= corr_mem[{bank, row_ff}];
      end
      if (cmd.bld_write && bld_row_end) begin
         corr_mem[{1'b0, i_ff}] <= acc_ff + contrib;
      end else if (cmd.copy_write) begin
         corr_mem[{1'b1, row_ff}] <= corr_rd_ff;
      end else if (cmd.walk_write) begin
         corr_mem[{bank, walk_r[RW-1:0]}] <= corr_rd_ff - walk_v;
      end
   end

   always_comb begin
      sts.func      = func_ff;
      sts.pos_valid = pos_valid;
      sts.bld_last  = bld_row_end && (i_ff == RW'(HALF - 1));
      sts.copy_last = row_ff == RW'(HALF - 1);
      sts.sum_last  = row_ff == RW'(HALF - 1);
      sts.walk_done = phase_ff == lfe_pkg::WALK_DONE;
      sts.touch_ok  = (phase_ff != lfe_pkg::WALK_DONE) && in_range && coord_ok;
   end

   assign rsp_energy = rsp_energy_ff;

endmodule

[hw/rtl/lfe_ctrl.sv]
`timescale 1ns / 1ps

module lfe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_func,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  lfe_pkg::sts_type sts,
   output lfe_pkg::cmd_type cmd
);

   lfe_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lfe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.cnt_clear = 1'b1;
               unique case (lfe_pkg::func_type'(req_func))
                  lfe_pkg::FUNC_LOAD:   state_in = lfe_pkg::ST_LOAD;
                  lfe_pkg::FUNC_BUILD:  state_in = lfe_pkg::ST_BLD_RD;
                  lfe_pkg::FUNC_EVAL:   state_in = lfe_pkg::ST_COPY_RD;
                  lfe_pkg::FUNC_COMMIT: state_in = lfe_pkg::ST_WALK_RD;
                  default:              state_in = lfe_pkg::ST_IDLE;
               endcase
            end
         end
         lfe_pkg::ST_LOAD: begin
            cmd.sign_wr = 1'b1;
            state_in    = lfe_pkg::ST_FINISH;
         end
         lfe_pkg::ST_BLD_RD: begin
            cmd.bld_issue = 1'b1;
            state_in      = lfe_pkg::ST_BLD_WR;
         end
         lfe_pkg::ST_BLD_WR: begin
            cmd.bld_write = 1'b1;
            state_in      = sts.bld_last ? lfe_pkg::ST_SUM_RD : lfe_pkg::ST_BLD_RD;
         end
         lfe_pkg::ST_COPY_RD: begin
            cmd.copy_issue = 1'b1;
            state_in       = lfe_pkg::ST_COPY_WR;
         end
         lfe_pkg::ST_COPY_WR: begin
            cmd.copy_write = 1'b1;
            if (sts.copy_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = lfe_pkg::ST_WALK_RD;
            end else begin
               state_in = lfe_pkg::ST_COPY_RD;
            end
         end
         lfe_pkg::ST_WALK_RD: begin
            if (!sts.pos_valid || sts.walk_done) begin
               if (sts.func == lfe_pkg::FUNC_COMMIT) begin
                  state_in = sts.pos_valid ? lfe_pkg::ST_FLIP_RD : lfe_pkg::ST_FINISH;
               end else begin
                  state_in = lfe_pkg::ST_SUM_RD;
               end
            end else if (sts.touch_ok) begin
               cmd.walk_issue = 1'b1;
               state_in       = lfe_pkg::ST_WALK_WR;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         lfe_pkg::ST_WALK_WR: begin
            cmd.walk_write = 1'b1;
            state_in       = lfe_pkg::ST_WALK_RD;
         end
         lfe_pkg::ST_FLIP_RD: begin
            cmd.flip_issue = 1'b1;
            state_in       = lfe_pkg::ST_FLIP_WR;
         end
         lfe_pkg::ST_FLIP_WR: begin
            cmd.flip_write = 1'b1;
            state_in       = lfe_pkg::ST_FINISH;
         end
         lfe_pkg::ST_SUM_RD: begin
            cmd.sum_issue = 1'b1;
            state_in      = lfe_pkg::ST_SUM_ACC;
         end
         lfe_pkg::ST_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = sts.sum_last ? lfe_pkg::ST_FINISH : lfe_pkg::ST_SUM_RD;
         end
         lfe_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = lfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfe_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.out_load;
   assign rsp_valid    = rsp_valid_ff;

endmodule

[hw/rtl/labs_flip_energy_engine.sv]
// From acceptance to result valid: load writes the sign bit and finishes; commit walks
// the table, then flips the sign; evaluate copies, walks and sums the correlations; build
// fills the table, then sums. Throughput: one item at a time; the walk and the sum take
// each table entry or correlation through a read state, then a write or accumulate state.
// Reset is synchronous and active high; it clears control only, so tables and signs
// hold no values until loaded and built.
`timescale 1ns / 1ps

module labs_flip_energy_engine #(
   parameter int SEQ_LEN = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_func,
   input  logic [lfe_pkg::POS_W-1:0]    req_position,
   input  logic                         req_sign_bit,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lfe_pkg::ENERGY_W-1:0] rsp_energy
);

   lfe_pkg::cmd_type cmd;
   lfe_pkg::sts_type sts;

   lfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfe_datapath #(
      .SEQ_LEN (SEQ_LEN)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_func     (req_func),
      .req_position (req_position),
      .req_sign_bit (req_sign_bit),
      .rsp_energy   (rsp_energy)
   );

`ifndef NO_ASSERTIONS
   a_walk_func: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_issue |-> sts.pos_valid &&
         (sts.func == lfe_pkg::FUNC_EVAL || sts.func == lfe_pkg::FUNC_COMMIT))
      else $error("table walk outside evaluate or commit");

   a_build_func: assert property (@(posedge clock) disable iff (reset)
      cmd.bld_issue |-> sts.func == lfe_pkg::FUNC_BUILD)
      else $error("table build outside build item");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && (sts.func == lfe_pkg::FUNC_LOAD || sts.func == lfe_pkg::FUNC_COMMIT))
      |=> rsp_valid && rsp_energy == '0)
      else $error("load or commit item returned nonzero energy");
`endif

endmodule
